[src/csvlp_pkg.sv]
// Shared types and constants for the comma-separated coordinate line parser.
// No dependencies; the top level imports this package.
`default_nettype none

package csvlp_pkg;

   // Default line length limit (bytes held plus the closing byte)
   localparam int LINE_LIMIT_DEFAULT = 128;

   // Character codes the parser reacts to
   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_L     = 8'h6C;
   localparam logic [7:0] CHR_X     = 8'h78;
   localparam logic [7:0] CHR_Y     = 8'h79;

   // Magnitude accumulator width and its saturation point
   localparam int                 ACC_W   = 17;
   localparam logic [ACC_W-1:0]   ACC_SAT = 17'd32768;

   // What the current or next token means
   typedef enum logic [1:0] {
      ROLE_KEY   = 2'd0,
      ROLE_X     = 2'd1,
      ROLE_Y     = 2'd2,
      ROLE_LABEL = 2'd3
   } role_type;

   // Progress through a decimal value token
   typedef enum logic [1:0] {
      NUM_SPACE   = 2'd0,
      NUM_DIGITS  = 2'd1,
      NUM_STOPPED = 2'd2
   } num_phase_type;

   // One result entry of the output buffer
   typedef struct packed {
      logic               valid;
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
      logic               ended_by_overflow;
   } rsp_entry_type;

endpackage

`default_nettype wire

[src/csvlp_if.sv]
// Valid/ready channel interfaces for the coordinate line parser.
// Byte input channel and coordinate result channel; no dependencies.
`default_nettype none

interface csvlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface csvlp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_value;
   logic signed [15:0] y_value;
   logic               ended_by_overflow;

   modport source (output valid, output x_value, output y_value,
                   output ended_by_overflow, input ready);
   modport sink   (input valid, input x_value, input y_value,
                   input ended_by_overflow, output ready);
endinterface

`default_nettype wire

[src/csv_coordinate_line_parser.sv]
// Top level of the comma-separated coordinate line parser.
// Depends on csvlp_pkg and the channel interfaces in csvlp_if.sv.
//
// The parser takes one byte per clock cycle, without gaps, for as long as its
// output buffer has room. Every byte updates the parse state in the cycle it
// is transferred; a byte that closes a line (newline, or any byte arriving
// with LINE_LIMIT-1 bytes held) puts one result with the latest X and Y into
// a two-entry output buffer (output register driving rsp_if, then skid). Input ready
// drops only while both buffer entries are full, so a stalled result side
// holds off the byte stream only after two undelivered results.
`default_nettype none

module csv_coordinate_line_parser
   import csvlp_pkg::*;
#(
   parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   csvlp_req_if.sink    req_if,
   csvlp_rsp_if.source  rsp_if
);

   localparam int CNT_W = $clog2(LINE_LIMIT);
   localparam logic [CNT_W-1:0] HELD_MAX = CNT_W'(LINE_LIMIT - 1);

   // Parse state
   logic [CNT_W-1:0] held_ff,     held_in;
   role_type         next_role_ff, next_role_in;
   role_type         cur_role_ff,  cur_role_in;
   logic             inside_ff,    inside_in;
   num_phase_type    phase_ff,     phase_in;
   logic             neg_ff,       neg_in;
   logic [ACC_W-1:0] acc_ff,       acc_in;
   logic             zero_seen_ff, zero_seen_in;
   logic [15:0]      latest_x_ff,  latest_x_in;
   logic [15:0]      latest_y_ff,  latest_y_in;

   // Output buffer
   rsp_entry_type    out_ff,  out_in;
   rsp_entry_type    skid_ff, skid_in;
   rsp_entry_type    result;

   logic             accept;
   logic             drain;
   logic [7:0]       c;
   logic             line_end;
   logic             is_digit;
   logic             is_space;
   logic             commit_x;
   logic             commit_y;
   logic [15:0]      commit_val;
   logic [15:0]      x_after;
   logic [15:0]      y_after;
   logic             starting;
   role_type         role_eff;
   num_phase_type    phase_base;
   logic             neg_base;
   logic [ACC_W-1:0] acc_base;
   logic [19:0]      acc_sum;
   logic [ACC_W-1:0] acc_next;

   assign req_if.ready = !skid_ff.valid;
   assign accept       = req_if.valid && req_if.ready;
   assign drain        = out_ff.valid && rsp_if.ready;
   assign c            = req_if.in_byte;

   assign rsp_if.valid             = out_ff.valid;
   assign rsp_if.x_value           = out_ff.x_value;
   assign rsp_if.y_value           = out_ff.y_value;
   assign rsp_if.ended_by_overflow = out_ff.ended_by_overflow;

   // Classify the incoming byte
   assign line_end = (c == CHR_LF) || (held_ff >= HELD_MAX);
   assign is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
   assign is_space = (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));

   // Value committed if the open token ends now
   assign commit_val = neg_ff ? 16'(~acc_ff + 17'd1)
                              : ((acc_ff > 17'd32767) ? 16'h7FFF : acc_ff[15:0]);
   assign commit_x   = inside_ff && (cur_role_ff == ROLE_X);
   assign commit_y   = inside_ff && (cur_role_ff == ROLE_Y);
   assign x_after    = commit_x ? commit_val : latest_x_ff;
   assign y_after    = commit_y ? commit_val : latest_y_ff;

   // Number state seen by a byte of a value token
   assign starting   = !inside_ff;
   assign role_eff   = starting ? next_role_ff : cur_role_ff;
   assign phase_base = starting ? NUM_SPACE : phase_ff;
   assign neg_base   = starting ? 1'b0 : neg_ff;
   assign acc_base   = starting ? '0 : acc_ff;

   // Accumulate one decimal digit, saturating the magnitude
   assign acc_sum  = ({3'b000, acc_base} * 20'd10) + {12'd0, c - CHR_ZERO};
   assign acc_next = (acc_sum > {3'b000, ACC_SAT}) ? ACC_SAT : acc_sum[ACC_W-1:0];

   // Next parse state for the transferred byte
   always_comb begin
      held_in      = held_ff;
      next_role_in = next_role_ff;
      cur_role_in  = cur_role_ff;
      inside_in    = inside_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      zero_seen_in = zero_seen_ff;
      latest_x_in  = latest_x_ff;
      latest_y_in  = latest_y_ff;
      if (accept) begin
         if (line_end) begin
            if (!zero_seen_ff) begin
               latest_x_in = x_after;
               latest_y_in = y_after;
            end
            held_in      = '0;
            next_role_in = ROLE_KEY;
            cur_role_in  = ROLE_KEY;
            inside_in    = 1'b0;
            phase_in     = NUM_SPACE;
            neg_in       = 1'b0;
            acc_in       = '0;
            zero_seen_in = 1'b0;
         end else begin
            held_in = held_ff + CNT_W'(1);
            if (!zero_seen_ff) begin
               if ((c == CHR_NUL) || (c == CHR_COMMA)) begin
                  // End the open token
                  latest_x_in  = x_after;
                  latest_y_in  = y_after;
                  inside_in    = 1'b0;
                  cur_role_in  = ROLE_KEY;
                  phase_in     = NUM_SPACE;
                  neg_in       = 1'b0;
                  acc_in       = '0;
                  zero_seen_in = (c == CHR_NUL);
               end else begin
                  inside_in   = 1'b1;
                  cur_role_in = role_eff;
                  phase_in    = phase_base;
                  neg_in      = neg_base;
                  acc_in      = acc_base;
                  if (starting) begin
                     if (next_role_ff == ROLE_KEY) begin
                        if (c == CHR_L) begin
                           next_role_in = ROLE_LABEL;
                        end else if (c == CHR_X) begin
                           next_role_in = ROLE_X;
                        end else if (c == CHR_Y) begin
                           next_role_in = ROLE_Y;
                        end
                     end else begin
                        next_role_in = ROLE_KEY;
                     end
                  end
                  // Feed the value converter
                  if ((role_eff == ROLE_X) || (role_eff == ROLE_Y)) begin
                     case (phase_base)
                        NUM_SPACE: begin
                           if ((c == CHR_PLUS) || (c == CHR_MINUS)) begin
                              neg_in   = (c == CHR_MINUS);
                              phase_in = NUM_DIGITS;
                           end else if (is_digit) begin
                              phase_in = NUM_DIGITS;
                              acc_in   = acc_next;
                           end else if (!is_space) begin
                              phase_in = NUM_STOPPED;
                           end
                        end
                        NUM_DIGITS: begin
                           if (is_digit) begin
                              acc_in = acc_next;
                           end else begin
                              phase_in = NUM_STOPPED;
                           end
                        end
                        default: begin
                           phase_in = phase_base;
                        end
                     endcase
                  end
               end
            end
         end
      end
   end

   // Result produced by a line-ending byte
   always_comb begin
      result.valid             = accept && line_end;
      result.x_value           = zero_seen_ff ? latest_x_ff : x_after;
      result.y_value           = zero_seen_ff ? latest_y_ff : y_after;
      result.ended_by_overflow = (c != CHR_LF);
   end

   // Advance the output buffer: skid entry refills the output register first
   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (!out_ff.valid || drain) begin
         if (skid_ff.valid) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end else begin
            out_in = result;
         end
      end else if (result.valid) begin
         skid_in = result;
      end
   end

   // Parse state and output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         next_role_ff  <= ROLE_KEY;
         cur_role_ff   <= ROLE_KEY;
         inside_ff     <= 1'b0;
         phase_ff      <= NUM_SPACE;
         neg_ff        <= 1'b0;
         acc_ff        <= '0;
         zero_seen_ff  <= 1'b0;
         latest_x_ff   <= '0;
         latest_y_ff   <= '0;
         out_ff        <= '0;
         skid_ff       <= '0;
      end else begin
         held_ff       <= held_in;
         next_role_ff  <= next_role_in;
         cur_role_ff   <= cur_role_in;
         inside_ff     <= inside_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         acc_ff        <= acc_in;
         zero_seen_ff  <= zero_seen_in;
         latest_x_ff   <= latest_x_in;
         latest_y_ff   <= latest_y_in;
         out_ff        <= out_in;
         skid_ff       <= skid_in;
      end
   end

`ifndef SYNTHESIS
   // Skid entry is only ever filled behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_ff.valid |-> out_ff.valid)
      else $error("skid entry valid with empty output register");

   // Held count never passes the line limit
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_MAX)
      else $error("held count beyond line limit");

   // After a zero byte no token stays open
   a_zero_closes: assert property (@(posedge clock) disable iff (reset)
      zero_seen_ff |-> !inside_ff)
      else $error("token open after zero byte");

   // Outside a token the current role is a key
   a_idle_role: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> (cur_role_ff == ROLE_KEY))
      else $error("role kept outside a token");

   // A line end clears the line state
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && line_end) |=> ((held_ff == '0) && !inside_ff && !zero_seen_ff))
      else $error("line state not cleared at line end");
`endif

endmodule

`default_nettype wire
